@@ rtl/lngsm_pkg.sv @@
// ----------------------------------------------------------------------------
// lngsm_pkg
// Shared types and constant tables of the Polish glyph slot mapper.
// ----------------------------------------------------------------------------
package lngsm_pkg;

    // Result kinds
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_CMD  = 2'd1;
    localparam logic [1:0] KIND_ROW  = 2'd2;

    // Glyph RAM address command base
    localparam logic [7:0] CMD_BASE = 8'h40;

    localparam int NUM_LETTERS = 18;
    localparam int LETTER_W    = 5;
    localparam int ROW_W       = 3;

    // ISO8859-2 codes of the Polish letters
    localparam logic [7:0] PL_CODES [NUM_LETTERS] = '{
        8'hA1, 8'hB1, 8'hC6, 8'hE6, 8'hCA, 8'hEA, 8'hA3, 8'hB3, 8'hD1,
        8'hF1, 8'hD3, 8'hF3, 8'hA6, 8'hB6, 8'hAC, 8'hBC, 8'hAF, 8'hBF
    };

    // Plain ASCII fallback letters
    localparam logic [7:0] PL_ASCII [NUM_LETTERS] = '{
        8'h41, 8'h61, 8'h43, 8'h63, 8'h45, 8'h65, 8'h4C, 8'h6C, 8'h4E,
        8'h6E, 8'h4F, 8'h6F, 8'h53, 8'h73, 8'h5A, 8'h7A, 8'h5A, 8'h7A
    };

    // Glyph ROM: row 0 in the low byte, row 7 in the high byte
    localparam logic [63:0] PL_GLYPHS [NUM_LETTERS] = '{
        64'h0211111F1111110E,
        64'h01020F110F010E00,
        64'h000E111010150E02,
        64'h000E1110100E0402,
        64'h021F10101C10101F,
        64'h01020E101F110E00,
        64'h001F101018141010,
        64'h000E04140C04060C,
        64'h0011111315191502,
        64'h0011111119160402,
        64'h000E111111150E01,
        64'h000E1111110E0402,
        64'h001E01010E140E01,
        64'h001E010E100E0402,
        64'h001F080402011F04,
        64'h001F0804021F0400,
        64'h001F080402091F04,
        64'h001F0804021F0402
    };

    // Controller to datapath commands
    typedef struct packed {
        logic take;    // accept a request and load its first result
        logic row;     // load the next glyph row
        logic fin;     // load the final slot character
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_load;  // current request claims a new slot
        logic out_free; // output register can take a result this cycle
        logic row_last; // next row to load is the last one
    } t_dp_stat;

endpackage

@@ rtl/lngsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// lngsm_ctrl
// Sequencer of the glyph load: command, eight rows, final character.
// ----------------------------------------------------------------------------
module lngsm_ctrl
    import lngsm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROWS,
        ST_FINAL
    } t_state;

    t_state r_state;
    t_state n_state;

    // Accept only between glyph loads
    assign o_in_ready = (r_state == ST_IDLE) && i_stat.out_free;

    // Issue commands and pick next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.take = 1'b1;
                    if (i_stat.is_load) begin
                        n_state = ST_ROWS;
                    end
                end
            end
            ST_ROWS: begin
                if (i_stat.out_free) begin
                    o_cmd.row = 1'b1;
                    if (i_stat.row_last) begin
                        n_state = ST_FINAL;
                    end
                end
            end
            ST_FINAL: begin
                if (i_stat.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/lngsm_dp.sv @@
// ----------------------------------------------------------------------------
// lngsm_dp
// Letter lookup, slot table, glyph row fetch and output register.
// ----------------------------------------------------------------------------
module lngsm_dp
    import lngsm_pkg::*;
#(
    parameter int SLOTS = 8
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_char_code,
    input  logic       i_frame_start,
    input  t_dp_cmd    i_cmd,
    output t_dp_stat   o_stat,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_value,
    output logic       o_last
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    logic [7:0]          r_slot_chars [SLOTS];
    logic [CNT_W-1:0]    r_used;
    logic [LETTER_W-1:0] r_letter;
    logic [SLOT_W-1:0]   r_slot;
    logic [ROW_W-1:0]    r_row;
    logic                r_valid;
    logic [1:0]          r_kind;
    logic [7:0]          r_value;
    logic                r_last;

    logic [CNT_W-1:0]    used_eff;
    logic                is_pl;
    logic [LETTER_W-1:0] letter;
    logic                hit;
    logic [SLOT_W-1:0]   hit_slot;
    logic                full;
    logic                is_load;
    logic [7:0]          single_value;
    logic                out_free;

    // Frame start empties the table before this character
    assign used_eff = i_frame_start ? '0 : r_used;

    // Find the Polish letter index
    always_comb begin
        is_pl  = 1'b0;
        letter = '0;
        for (int k = 0; k < NUM_LETTERS; k++) begin
            if (!is_pl && (i_char_code == PL_CODES[k])) begin
                is_pl  = 1'b1;
                letter = LETTER_W'(k);
            end
        end
    end

    // Compare written slots only
    always_comb begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int k = 0; k < SLOTS; k++) begin
            if (!hit && (CNT_W'(k) < used_eff) && (r_slot_chars[k] == i_char_code)) begin
                hit      = 1'b1;
                hit_slot = SLOT_W'(k);
            end
        end
    end

    assign full    = (used_eff >= CNT_W'(SLOTS));
    assign is_load = is_pl && !hit && !full;

    // Single-result value: pass through, slot number or ASCII base letter
    always_comb begin
        priority if (!is_pl) begin
            single_value = i_char_code;
        end else if (hit) begin
            single_value = 8'(hit_slot);
        end else begin
            single_value = PL_ASCII[letter];
        end
    end

    assign out_free = !r_valid || i_ready;

    assign o_stat.is_load  = is_load;
    assign o_stat.out_free = out_free;
    assign o_stat.row_last = (r_row == ROW_W'(7));

    // Slot table and load context
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_row  <= '0;
        end else begin
            if (i_cmd.take) begin
                r_used <= used_eff;
                r_row  <= '0;
                if (is_load) begin
                    r_used <= used_eff + CNT_W'(1);
                end
            end else if (i_cmd.row) begin
                r_row <= r_row + ROW_W'(1);
            end
        end
    end

    // Table entries and glyph context need no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && is_load) begin
            r_slot_chars[used_eff[SLOT_W-1:0]] <= i_char_code;
            r_letter <= letter;
            r_slot   <= used_eff[SLOT_W-1:0];
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.take || i_cmd.row || i_cmd.fin) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            if (is_load) begin
                r_kind  <= KIND_CMD;
                r_value <= CMD_BASE + 8'({used_eff[SLOT_W-1:0], 3'b000});
                r_last  <= 1'b0;
            end else begin
                r_kind  <= KIND_CHAR;
                r_value <= single_value;
                r_last  <= 1'b1;
            end
        end else if (i_cmd.row) begin
            r_kind  <= KIND_ROW;
            r_value <= PL_GLYPHS[r_letter][{r_row, 3'b000} +: 8];
            r_last  <= 1'b0;
        end else if (i_cmd.fin) begin
            r_kind  <= KIND_CHAR;
            r_value <= 8'(r_slot);
            r_last  <= 1'b1;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_value = r_value;
    assign o_last  = r_last;

endmodule

@@ rtl/lcd_national_glyph_slot_mapper.sv @@
// ----------------------------------------------------------------------------
// lcd_national_glyph_slot_mapper
// Maps Polish letters of a display frame onto user-definable LCD glyph slots.
// ----------------------------------------------------------------------------
// Input stream: s_axis_tdata carries the character byte, s_axis_tuser marks
// the first character of a frame, which empties the slot table first.
// Output stream: m_axis_tdata is the value, m_axis_tuser the kind (display
// character, command byte, glyph row byte), m_axis_tlast the final result of
// a request, always the display character.
// A plain character, a letter already in a slot, or a letter with the table
// full gives one result, registered on acceptance; such requests
// go at one per cycle while the receiver keeps up.
// A letter claiming a new slot gives ten results: address command, eight
// glyph rows, slot number, one per cycle while the receiver keeps up. The
// input stays stalled after acceptance while the load sequencer walks the
// glyph ROM, so no new request is taken until the slot number is registered.
// A receiver stall holds the output register and blocks new requests.
// Reset empties the slot table and the output register.
// ----------------------------------------------------------------------------
module lcd_national_glyph_slot_mapper
    import lngsm_pkg::*;
#(
    parameter int SLOTS = 8
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_code
    input  logic       s_axis_tuser,   // [0] frame_start
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] value
    output logic [1:0] m_axis_tuser,   // [1:0] kind
    output logic       m_axis_tlast
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    lngsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lngsm_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_char_code   (s_axis_tdata),
        .i_frame_start (s_axis_tuser),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_kind        (m_axis_tuser),
        .o_value       (m_axis_tdata),
        .o_last        (m_axis_tlast)
    );

    // An accepted request always leaves a result in the output register
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("no result after accepted request");

    // No new request while a glyph load is still being delivered
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != KIND_CHAR) |-> !s_axis_tready)
        else $error("request accepted during glyph load");

    // Only a display character closes a request
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_CHAR)
        else $error("last flag on non-character result");

endmodule

@@ sim/lngsm_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lngsm_checker
// Watches both streams of the glyph slot mapper and checks every result.
// ----------------------------------------------------------------------------
// Each accepted request is run through a local model of the slot table. The
// results that the model gives are queued in order. Each accepted result is
// compared field by field against the oldest queued entry. The failure count
// and the number of results still due are handed to the testbench top.
// ----------------------------------------------------------------------------
module lngsm_checker
    import lngsm_pkg::*;
#(
    parameter int SLOTS = 8
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] char_code
    input  logic       i_s_tuser,   // [0] frame_start
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,   // [7:0] value
    input  logic [1:0] i_m_tuser,   // [1:0] kind
    input  logic       i_m_tlast,
    output int         o_fail_cnt,
    output int         o_pending
);

    localparam int REPORT_MAX = 100;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       last;
    } t_lcd_result;

    // Properties of one Polish letter; glyph row 0 sits in the top byte
    typedef struct packed {
        logic        hit;
        logic [7:0]  base;
        logic [63:0] glyph;
    } t_letter;

    t_lcd_result lcd_results_q[$];
    logic [7:0]  slot_code [8];
    int unsigned slot_cnt;

    // Look up a character among the Polish letters
    function automatic t_letter lookup_letter(input logic [7:0] ch);
        t_letter l;
        l.hit   = 1'b1;
        l.base  = 8'h00;
        l.glyph = '0;
        unique case (ch)
            8'hA1: begin l.base = 8'h41; l.glyph = 64'h0E1111111F111102; end
            8'hB1: begin l.base = 8'h61; l.glyph = 64'h000E010F110F0201; end
            8'hC6: begin l.base = 8'h43; l.glyph = 64'h020E151010110E00; end
            8'hE6: begin l.base = 8'h63; l.glyph = 64'h02040E1010110E00; end
            8'hCA: begin l.base = 8'h45; l.glyph = 64'h1F10101C10101F02; end
            8'hEA: begin l.base = 8'h65; l.glyph = 64'h000E111F100E0201; end
            8'hA3: begin l.base = 8'h4C; l.glyph = 64'h1010141810101F00; end
            8'hB3: begin l.base = 8'h6C; l.glyph = 64'h0C06040C14040E00; end
            8'hD1: begin l.base = 8'h4E; l.glyph = 64'h0215191513111100; end
            8'hF1: begin l.base = 8'h6E; l.glyph = 64'h0204161911111100; end
            8'hD3: begin l.base = 8'h4F; l.glyph = 64'h010E151111110E00; end
            8'hF3: begin l.base = 8'h6F; l.glyph = 64'h02040E1111110E00; end
            8'hA6: begin l.base = 8'h53; l.glyph = 64'h010E140E01011E00; end
            8'hB6: begin l.base = 8'h73; l.glyph = 64'h02040E100E011E00; end
            8'hAC: begin l.base = 8'h5A; l.glyph = 64'h041F010204081F00; end
            8'hBC: begin l.base = 8'h7A; l.glyph = 64'h00041F0204081F00; end
            8'hAF: begin l.base = 8'h5A; l.glyph = 64'h041F090204081F00; end
            8'hBF: begin l.base = 8'h7A; l.glyph = 64'h02041F0204081F00; end
            default: l.hit = 1'b0;
        endcase
        return l;
    endfunction

    task automatic queue_result(input logic [1:0] kind, input logic [7:0] value,
                                input logic last);
        t_lcd_result r;
        r.kind  = kind;
        r.value = value;
        r.last  = last;
        lcd_results_q.push_back(r);
    endtask

    // Map one request onto the slot table and queue the results it gives
    task automatic map_char(input logic [7:0] ch, input logic fs);
        t_letter info;
        int      hit_slot;
        info     = lookup_letter(ch);
        hit_slot = -1;
        if (fs) begin
            slot_cnt = 0;
        end
        if (!info.hit) begin
            queue_result(KIND_CHAR, ch, 1'b1);
        end else begin
            for (int i = 0; i < slot_cnt; i++) begin
                if (hit_slot < 0 && slot_code[i] == ch) begin
                    hit_slot = i;
                end
            end
            if (hit_slot >= 0) begin
                queue_result(KIND_CHAR, 8'(hit_slot), 1'b1);
            end else if (slot_cnt >= SLOTS) begin
                // table full: fall back to the plain letter
                queue_result(KIND_CHAR, info.base, 1'b1);
            end else begin
                // claim the next slot and load its glyph
                queue_result(KIND_CMD, CMD_BASE + 8'(slot_cnt * 8), 1'b0);
                for (int r = 0; r < 8; r++) begin
                    queue_result(KIND_ROW, info.glyph[63 - 8 * r -: 8], 1'b0);
                end
                slot_code[slot_cnt] = ch;
                queue_result(KIND_CHAR, 8'(slot_cnt), 1'b1);
                slot_cnt++;
            end
        end
    endtask

    task automatic report(input string what, input logic [7:0] want, input logic [7:0] got);
        o_fail_cnt++;
        if (o_fail_cnt <= REPORT_MAX) begin
            $display("%0t: %s mismatch: expected 0x%02h, actual 0x%02h", $time, what, want, got);
        end
    endtask

    // Check results first, then queue the results of a new request
    always @(posedge i_clk) begin : chk_proc
        t_lcd_result want;
        if (!i_rst_n) begin
            slot_cnt = 0;
            lcd_results_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (lcd_results_q.size() == 0) begin
                    o_fail_cnt++;
                    if (o_fail_cnt <= REPORT_MAX) begin
                        $display({"%0t: unexpected result: expected none, ",
                                  "actual kind %0d value 0x%02h last %0d"},
                                 $time, i_m_tuser, i_m_tdata, i_m_tlast);
                    end
                end else begin
                    want = lcd_results_q.pop_front();
                    if (want.kind !== i_m_tuser) begin
                        report("kind", 8'(want.kind), 8'(i_m_tuser));
                    end
                    if (want.value !== i_m_tdata) begin
                        report("value", want.value, i_m_tdata);
                    end
                    if (want.last !== i_m_tlast) begin
                        report("last", 8'(want.last), 8'(i_m_tlast));
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                map_char(i_s_tdata, i_s_tuser);
            end
        end
        o_pending <= lcd_results_q.size();
    end

endmodule

@@ sim/tb_lcd_national_glyph_slot_mapper.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lcd_national_glyph_slot_mapper
// Stimulus and verdict for the Polish glyph slot mapper.
// ----------------------------------------------------------------------------
// A directed pass fills the slot table, overflows it, hits held slots and
// restarts frames. Random frames of mixed Polish letters and arbitrary bytes
// follow, with random gaps on the request side and random receiver stalls.
// Checking lives in lngsm_checker; this top only drives and decides.
// ----------------------------------------------------------------------------
module tb_lcd_national_glyph_slot_mapper;

    localparam int RUN_ITEMS   = 370;
    localparam int QUIET_ITEMS = 60;
    localparam int CYCLE_LIMIT = 200000;

    // The eighteen Polish letter codes, first code in the low byte
    localparam logic [143:0] PL_SET = {
        8'hBF, 8'hAF, 8'hBC, 8'hAC, 8'hB6, 8'hA6, 8'hF3, 8'hD3, 8'hF1,
        8'hD1, 8'hB3, 8'hA3, 8'hEA, 8'hCA, 8'hE6, 8'hC6, 8'hB1, 8'hA1
    };

    logic       i_clk    = 1'b0;
    logic       i_rst_n  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tuser  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    int         fail_cnt;
    int         pending;
    int         sent;
    int         stall_left;
    int         cycle_cnt;
    int         run_total;
    int         frame_len;
    bit         idle_on;
    logic [7:0] ch;
    logic       fs;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    lcd_national_glyph_slot_mapper dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    lngsm_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .i_m_tlast  (m_tlast),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    // Stall the receiver in bursts of random length
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 4);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offer one request, after an optional gap, and hold it until taken
    task automatic send_char(input logic [7:0] code, input logic start);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tuser  <= start;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent++;
    endtask

    // Hold off requests until every queued result has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        idle_on = 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Plain characters at the byte extremes
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b0);
        // New frame with a letter, then a hit on its slot
        send_char(8'hA1, 1'b1);
        send_char(8'hA1, 1'b0);
        // Fill the remaining slots
        send_char(8'hB1, 1'b0);
        send_char(8'hC6, 1'b0);
        send_char(8'hE6, 1'b0);
        send_char(8'hCA, 1'b0);
        send_char(8'hEA, 1'b0);
        send_char(8'hA3, 1'b0);
        send_char(8'hB3, 1'b0);
        // Table full: plain letter, then a hit on the last slot
        send_char(8'hD1, 1'b0);
        send_char(8'hB3, 1'b0);
        // Frame restarts on plain characters and on a letter, twice in a row
        send_char(8'h7F, 1'b1);
        send_char(8'h80, 1'b1);
        send_char(8'hBF, 1'b1);
        send_char(8'hBF, 1'b1);
        // Remaining letters, the last one overflowing the table
        send_char(8'hF1, 1'b0);
        send_char(8'hD3, 1'b0);
        send_char(8'hF3, 1'b0);
        send_char(8'hA6, 1'b0);
        send_char(8'hB6, 1'b0);
        send_char(8'hAC, 1'b0);
        send_char(8'hBC, 1'b0);
        send_char(8'hAF, 1'b0);
        wait_drained();

        // Random frames, mostly well formed, some broken by stray frame starts
        run_total = sent + RUN_ITEMS;
        while (sent < run_total) begin
            frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 16);
            idle_on = (sent < run_total - QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < frame_len; k++) begin
                // Run the closing stretch at full speed
                if (sent >= run_total - QUIET_ITEMS) begin
                    idle_on = 1'b0;
                end
                if ($urandom_range(0, 9) < 6) begin
                    ch = PL_SET[8 * $urandom_range(0, 17) +: 8];
                end else begin
                    ch = 8'($urandom_range(0, 255));
                end
                fs = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
                send_char(ch, fs);
            end
            if ($urandom_range(0, 7) == 0) begin
                wait_drained();
            end
        end

        // Drain and let the block settle
        wait_drained();
        repeat (12) @(posedge i_clk);
        if (fail_cnt == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/lngsm_pkg.sv
rtl/lngsm_ctrl.sv
rtl/lngsm_dp.sv
rtl/lcd_national_glyph_slot_mapper.sv
sim/lngsm_checker.sv
sim/tb_lcd_national_glyph_slot_mapper.sv
